// ===== sv/gradient_color_ramp_unit_assert.svh =====
// assertion macros shared by the ramp unit
`ifndef GRADIENT_COLOR_RAMP_UNIT_ASSERT_SVH
`define GRADIENT_COLOR_RAMP_UNIT_ASSERT_SVH

// condition on the same edge
`define GCR_ASSERT_NOW(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("ramp unit check failed");

// condition on the following edge
`define GCR_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("ramp unit check failed");

`endif

// ===== sv/gcr_pkg.sv =====
package gcr_pkg;
	parameter int MAX_STOPS = 16;
	parameter int IDX_W = $clog2(MAX_STOPS);
	parameter int CNT_W = $clog2(MAX_STOPS + 1);
	parameter int CH_W = 16;
	parameter int COL_W = 4 * CH_W;
	parameter int DIV_CNT_W = $clog2(CH_W + 1);

	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_EVAL  = 2'd1;
	localparam logic [1:0] OP_BLANK = 2'd2;

	typedef struct packed {
		logic [1:0]       op;
		logic [CH_W-1:0]  pos;
		logic [COL_W-1:0] color;
	} gcr_item_t;

	typedef struct packed {
		logic              start;
		logic [2*CH_W-1:0] num;
		logic [CH_W-1:0]   den;
	} gcr_div_req_t;

	typedef struct packed {
		logic            done;
		logic [CH_W-1:0] quot;
	} gcr_div_rsp_t;
endpackage

// ===== sv/gcr_front.sv =====
module gcr_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  cmd,
	input  logic [15:0]           position,
	input  logic                  outside,
	input  logic [15:0]           red,
	input  logic [15:0]           green,
	input  logic [15:0]           blue,
	input  logic [15:0]           opacity,
	output gcr_pkg::gcr_item_t    head,
	output logic                  head_valid,
	input  logic                  pop
);
	gcr_pkg::gcr_item_t ent_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         cnt_q;
	logic               push;
	gcr_pkg::gcr_item_t item;

	// classify: outside evaluates never need the table
	always_comb begin
		if (!cmd) begin
			item.op = gcr_pkg::OP_ADD;
		end else if (outside) begin
			item.op = gcr_pkg::OP_BLANK;
		end else begin
			item.op = gcr_pkg::OP_EVAL;
		end
		item.pos = position;
		item.color = {opacity, blue, green, red};
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign head = ent_q[rd_ptr_q];
	assign head_valid = (cnt_q != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= item;
		end
	end
endmodule

// ===== sv/gcr_div.sv =====
module gcr_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  gcr_pkg::gcr_div_req_t req,
	output gcr_pkg::gcr_div_rsp_t rsp
);
	logic                           busy_q;
	logic                           done_q;
	logic [gcr_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic [gcr_pkg::CH_W-1:0]       rem_q;
	logic [gcr_pkg::CH_W-1:0]       sh_q;
	logic [gcr_pkg::CH_W-1:0]       den_q;
	logic [gcr_pkg::CH_W:0]         trial;
	logic                           ge;

	// restoring division, one quotient bit per cycle; upper half of
	// the numerator is known to be below the divisor
	assign trial = {rem_q, sh_q[gcr_pkg::CH_W-1]};
	assign ge = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= gcr_pkg::DIV_CNT_W'(gcr_pkg::CH_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == gcr_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num[2*gcr_pkg::CH_W-1:gcr_pkg::CH_W];
			sh_q <= req.num[gcr_pkg::CH_W-1:0];
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= ge ? gcr_pkg::CH_W'(trial - {1'b0, den_q})
			            : trial[gcr_pkg::CH_W-1:0];
			sh_q <= {sh_q[gcr_pkg::CH_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = sh_q;
endmodule

// ===== sv/gcr_back.sv =====
module gcr_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  gcr_pkg::gcr_item_t    head,
	input  logic                  head_valid,
	output logic                  pop,
	output gcr_pkg::gcr_div_req_t div_req,
	input  gcr_pkg::gcr_div_rsp_t div_rsp,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [15:0]           out_red,
	output logic [15:0]           out_green,
	output logic [15:0]           out_blue,
	output logic [15:0]           out_opacity,
	output logic                  stop_dropped
);
	localparam int MS = gcr_pkg::MAX_STOPS;
	localparam int IW = gcr_pkg::IDX_W;
	localparam int CW = gcr_pkg::CNT_W;
	localparam int HW = gcr_pkg::CH_W;
	localparam int KW = gcr_pkg::COL_W;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_FIRST = 3'd1;
	localparam logic [2:0] ST_LAST  = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_MUL   = 3'd5;
	localparam logic [2:0] ST_FIX   = 3'd6;

	logic [HW-1:0]   off_q [MS];
	logic [KW-1:0]   col_q [MS];
	logic [CW-1:0]   count_q;
	logic [2:0]      state_q;
	logic [IW-1:0]   idx_q;
	logic [1:0]      ch_q;
	logic [HW-1:0]   pos_q;
	logic [HW-1:0]   lo_off_q;
	logic [KW-1:0]   lo_col_q;
	logic [KW-1:0]   hi_col_q;
	logic [HW-1:0]   lt_q;
	logic [2*HW-1:0] prod_q;
	logic            neg_q;
	logic [HW-1:0]   base_q;
	logic [HW-1:0]   res_q [3];
	logic            out_valid_q;
	logic [KW-1:0]   out_col_q;
	logic            out_drop_q;

	logic            out_free;
	logic [HW-1:0]   rd_off;
	logic [KW-1:0]   rd_col;
	logic            pos_le_rd;
	logic            pos_ge_rd;
	logic            full;
	logic            do_insert;
	logic [MS-1:0]   greater;
	logic [MS-1:0]   take_prev;
	logic [MS-1:0]   take_new;
	logic            load_out;
	logic [KW-1:0]   out_col_d;
	logic            out_drop_d;
	logic [HW-1:0]   ch_a;
	logic [HW-1:0]   ch_b;
	logic [HW-1:0]   mag;
	logic [HW-1:0]   q0;
	logic [HW:0]     rsum;
	logic [HW-1:0]   quo;
	logic [HW-1:0]   chan_v;
	logic [HW-1:0]   diff;

	assign out_free = !out_valid_q || out_ready;
	assign pop = (state_q == ST_IDLE) && head_valid && out_free;
	assign rd_off = off_q[idx_q];
	assign rd_col = col_q[idx_q];
	assign pos_le_rd = (pos_q <= rd_off);
	assign pos_ge_rd = (pos_q >= rd_off);
	assign full = (count_q == CW'(MS));
	assign do_insert = pop && (head.op == gcr_pkg::OP_ADD) && !full;

	// insertion slot: entries above the new offset move up one place
	always_comb begin
		for (int i = 0; i < MS; i++) begin
			greater[i] = (CW'(i) < count_q) && (off_q[i] > head.pos);
		end
		take_prev[0] = 1'b0;
		for (int i = 1; i < MS; i++) begin
			take_prev[i] = greater[i-1];
		end
		for (int i = 0; i < MS; i++) begin
			take_new[i] = !take_prev[i] && (greater[i] || (CW'(i) == count_q));
		end
	end

	// channel arithmetic, one channel at a time
	assign ch_a = lo_col_q[ch_q*HW +: HW];
	assign ch_b = hi_col_q[ch_q*HW +: HW];
	assign mag = (ch_b < ch_a) ? (ch_a - ch_b) : (ch_b - ch_a);
	// divide by 65535: high half plus a single correction
	assign q0 = prod_q[2*HW-1:HW];
	assign rsum = {1'b0, prod_q[HW-1:0]} + {1'b0, q0};
	assign quo = q0 + HW'(rsum >= {1'b0, {HW{1'b1}}});
	assign chan_v = neg_q ? (base_q - quo) : (base_q + quo);
	assign diff = pos_q - lo_off_q;

	always_comb begin
		div_req.start = (state_q == ST_SCAN) && pos_le_rd;
		div_req.num = {diff, {HW{1'b0}}} - {{HW{1'b0}}, diff};
		div_req.den = rd_off - lo_off_q;
	end

	always_comb begin
		load_out = 1'b0;
		out_col_d = '0;
		out_drop_d = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (pop) begin
					if (head.op == gcr_pkg::OP_ADD) begin
						load_out = 1'b1;
						out_drop_d = full;
					end else if (head.op != gcr_pkg::OP_EVAL || count_q == '0) begin
						load_out = 1'b1;
					end
				end
			end
			ST_FIRST: begin
				load_out = pos_le_rd;
				out_col_d = rd_col;
			end
			ST_LAST: begin
				load_out = pos_ge_rd;
				out_col_d = rd_col;
			end
			ST_FIX: begin
				load_out = (ch_q == 2'd3);
				out_col_d = {chan_v, res_q[2], res_q[1], res_q[0]};
			end
			ST_SCAN, ST_DIV, ST_MUL: begin
				load_out = 1'b0;
			end
			default: begin
				load_out = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			ch_q <= '0;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (do_insert) begin
				count_q <= count_q + 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop && head.op == gcr_pkg::OP_EVAL && count_q != '0) begin
						state_q <= ST_FIRST;
						idx_q <= '0;
					end
				end
				ST_FIRST: begin
					if (pos_le_rd) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_LAST;
						idx_q <= IW'(count_q - 1'b1);
					end
				end
				ST_LAST: begin
					if (pos_ge_rd) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_SCAN;
						idx_q <= IW'(1);
					end
				end
				ST_SCAN: begin
					if (pos_le_rd) begin
						state_q <= ST_DIV;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_MUL;
						ch_q <= '0;
					end
				end
				ST_MUL: begin
					state_q <= ST_FIX;
				end
				ST_FIX: begin
					if (ch_q == 2'd3) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_MUL;
						ch_q <= ch_q + 2'd1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pos_q <= head.pos;
		end
		if ((state_q == ST_FIRST) || (state_q == ST_SCAN && !pos_le_rd)) begin
			lo_off_q <= rd_off;
			lo_col_q <= rd_col;
		end
		if (state_q == ST_SCAN && pos_le_rd) begin
			hi_col_q <= rd_col;
		end
		if (state_q == ST_DIV && div_rsp.done) begin
			lt_q <= div_rsp.quot;
		end
		if (state_q == ST_MUL) begin
			prod_q <= (2*HW)'(mag) * (2*HW)'(lt_q);
			neg_q <= (ch_b < ch_a);
			base_q <= ch_a;
		end
		if (state_q == ST_FIX && ch_q != 2'd3) begin
			res_q[ch_q] <= chan_v;
		end
		if (load_out) begin
			out_col_q <= out_col_d;
			out_drop_q <= out_drop_d;
		end
		if (do_insert) begin
			for (int i = 0; i < MS; i++) begin
				if (take_prev[i]) begin
					off_q[i] <= off_q[i-1];
					col_q[i] <= col_q[i-1];
				end else if (take_new[i]) begin
					off_q[i] <= head.pos;
					col_q[i] <= head.color;
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_red = out_col_q[HW-1:0];
	assign out_green = out_col_q[2*HW-1:HW];
	assign out_blue = out_col_q[3*HW-1:2*HW];
	assign out_opacity = out_col_q[4*HW-1:3*HW];
	assign stop_dropped = out_drop_q;
endmodule

// ===== sv/gradient_color_ramp_unit.sv =====
// Gradient color ramp: keeps up to 16 color stops sorted by offset and
// answers color lookups, one result per item, in order. Items pass a
// two-entry queue into the execution sequencer. An add, an outside or an
// empty-table evaluate is answered from the idle state. An evaluate at or
// below the first stop's offset, or at or above the last stop's, clamps to
// that stop; one that falls between stops goes through the table scan
// (one entry per cycle, k (0..n-2) stops stepped over), the bit-serial
// divider forming the blend weight, and the single multiplier shared by
// the four channels. The sequencer takes the next item only once the
// output register is empty or its result is taken in that same cycle; while
// a result waits, the queue keeps accepting until both entries are filled.
module gradient_color_ramp_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [15:0] position,
	input  logic        outside,
	input  logic [15:0] red,
	input  logic [15:0] green,
	input  logic [15:0] blue,
	input  logic [15:0] opacity,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] out_red,
	output logic [15:0] out_green,
	output logic [15:0] out_blue,
	output logic [15:0] out_opacity,
	output logic        stop_dropped
);
	gcr_pkg::gcr_item_t    head;
	logic                  head_valid;
	logic                  pop;
	gcr_pkg::gcr_div_req_t div_req;
	gcr_pkg::gcr_div_rsp_t div_rsp;

	gcr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.position   (position),
		.outside    (outside),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.opacity    (opacity),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop)
	);

	gcr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	gcr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.head_valid   (head_valid),
		.pop          (pop),
		.div_req      (div_req),
		.div_rsp      (div_rsp),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_red      (out_red),
		.out_green    (out_green),
		.out_blue     (out_blue),
		.out_opacity  (out_opacity),
		.stop_dropped (stop_dropped)
	);

`include "gradient_color_ramp_unit_assert.svh"

	// a dropped stop carries no color
	`GCR_ASSERT_NOW(a_drop_no_color, out_valid && stop_dropped, out_red == 16'd0 && out_green == 16'd0 && out_blue == 16'd0 && out_opacity == 16'd0)
	// the sequencer only takes from a filled queue
	`GCR_ASSERT_NOW(a_pop_needs_item, pop, head_valid)
	// divider does not report done in the cycle after a start
	`GCR_ASSERT_NEXT(a_div_not_instant, div_req.start, !div_rsp.done)
endmodule
